// ===== rtl/nfh_pkg.sv =====
`default_nettype none
package nfh_pkg;

  localparam int IdW      = 16;
  localparam int IdBits   = 16;
  localparam int LatW     = 24;
  localparam int LonW     = 25;
  localparam int DistW    = 18;
  localparam int AngW     = 40;
  localparam int DatW     = 34;
  localparam int Iters    = 24;
  localparam int IterW    = 5;
  localparam int CfgIdxW  = 2;
  localparam int CfgDatW  = 25;

  localparam logic [CfgIdxW-1:0] CfgHomeLat = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHomeLon = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHomeId  = 2'd2;

  localparam logic signed [AngW-1:0] DegFull    = 40'sd377487360;
  localparam logic signed [AngW-1:0] DegHalf    = 40'sd188743680;
  localparam logic signed [AngW-1:0] DegQuarter = 40'sd94371840;
  localparam logic signed [DatW-1:0] Q30        = 34'sd1073741824;
  localparam logic signed [DatW-1:0] CordicStart = 34'sd652032874;
  localparam logic [23:0] DistMul  = 24'd9061334;
  localparam logic [DistW-1:0] DistMax   = 18'd199104;
  localparam logic [DistW-1:0] NearReset = 18'h3FFFF;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SC_LOAD, ST_SC_RUN, ST_PROD, ST_SQ_LOAD, ST_SQ_RUN,
    ST_AT_RUN, ST_DIST, ST_UPDATE, ST_OUT
  } state_e;

  typedef struct packed {
    logic        start;
    logic        vec_mode;
    logic signed [AngW-1:0] angle;
    logic signed [DatW-1:0] x0;
    logic signed [DatW-1:0] y0;
  } cordic_cmd_t;

  function automatic logic signed [AngW-1:0] atan_lut(input logic [IterW-1:0] i);
    case (i)
      5'd0: atan_lut = 40'sd47185920;   5'd1: atan_lut = 40'sd27855475;
      5'd2: atan_lut = 40'sd14718068;   5'd3: atan_lut = 40'sd7471121;
      5'd4: atan_lut = 40'sd3750058;    5'd5: atan_lut = 40'sd1876857;
      5'd6: atan_lut = 40'sd938658;     5'd7: atan_lut = 40'sd469357;
      5'd8: atan_lut = 40'sd234682;     5'd9: atan_lut = 40'sd117342;
      5'd10: atan_lut = 40'sd58671;     5'd11: atan_lut = 40'sd29335;
      5'd12: atan_lut = 40'sd14668;     5'd13: atan_lut = 40'sd7334;
      5'd14: atan_lut = 40'sd3667;      5'd15: atan_lut = 40'sd1833;
      5'd16: atan_lut = 40'sd917;       5'd17: atan_lut = 40'sd458;
      5'd18: atan_lut = 40'sd229;       5'd19: atan_lut = 40'sd115;
      5'd20: atan_lut = 40'sd57;        5'd21: atan_lut = 40'sd29;
      5'd22: atan_lut = 40'sd14;        5'd23: atan_lut = 40'sd7;
      default: atan_lut = '0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== rtl/nearest_farthest_haversine_top.sv =====
`default_nettype none
// Channel   | Dir | Signals                     | Contents (low bit first)
// s_axis    | in  | tvalid/tready/tdata/tlast   | tdata: point_id, point_latitude,
//           |     |                             |   point_longitude; tlast: last_point
// m_axis    | out | tvalid/tready/tdata         | nearest_id, nearest_distance,
//           |     |                             |   nearest_found, farthest_id,
//           |     |                             |   farthest_distance, farthest_found
// cfg       | in  | cfg_we/cfg_idx/cfg_wdata    | 0 home_lat, 1 home_lon, 2 home_id
//
// A candidate runs, after acceptance, four sin/cos CORDIC passes, the products on
// one multiplier, two square roots (31 bit pairs each), a CORDIC vectoring pass,
// then the distance and update states. A zero first root skips the vectoring
// pass. Home-id candidates go straight to the update state and leave the search
// unchanged. After a last item, ST_OUT latches the result. Reset clears control
// state, home config and search results; datapath registers are not reset.
// s_axis_tready is low while a candidate is processed or a result waits on m_axis.
module nearest_farthest_haversine_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [71:0]  s_axis_tdata,   // point_id, point_latitude, point_longitude
  input  wire logic         s_axis_tlast,   // last_point
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [71:0]       m_axis_tdata,   // near id,dist,found, far id,dist,found
  input  wire logic         cfg_we_i,
  input  wire logic [nfh_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [nfh_pkg::CfgDatW-1:0] cfg_wdata_i
);
  import nfh_pkg::*;

  state_e st_q, st_d;
  logic signed [LatW-1:0] hlat_q, plat_q;
  logic signed [LonW-1:0] hlon_q, plon_q;
  logic [IdW-1:0] hid_q, pid_q;
  logic last_q;
  logic skip_q;
  logic [1:0] sc_q, sc_d;          // which sin/cos pass
  logic [2:0] pr_q, pr_d;          // product step
  logic sq_q, sq_d;                // which root
  logic signed [DatW-1:0] s1_q, s2_q, c1_q, c2_q, a_q, ry_q, rx_q;
  logic signed [AngW-1:0] z_q;
  logic [DistW-1:0] dist_q;
  logic [DistW-1:0] bnd_q, bfd_q;
  logic [IdW-1:0] bni_q, bfi_q;
  logic nv_q, fv_q;
  logic [71:0] out_q;
  logic ov_q;

  // CORDIC command
  cordic_cmd_t cmd;
  logic cdone, sdone;
  logic signed [DatW-1:0] cx, cy;
  logic signed [AngW-1:0] cz;
  logic sstart;
  logic [61:0] sval;
  logic [30:0] sroot;

  nfh_cordic u_cordic (.clk_i, .rst_ni, .cmd_i(cmd), .done_o(cdone),
                       .x_o(cx), .y_o(cy), .z_o(cz));
  nfh_sqrt u_sqrt (.clk_i, .rst_ni, .start_i(sstart), .val_i(sval),
                   .done_o(sdone), .root_o(sroot));

  // angle reduction for the current sin/cos pass
  logic signed [AngW-1:0] th, t0, t1;
  logic flip;
  always_comb begin
    unique case (sc_q)
      2'd0: th = (AngW'(plat_q) - AngW'(hlat_q)) <<< 3;
      2'd1: th = (AngW'(plon_q) - AngW'(hlon_q)) <<< 3;
      2'd2: th = AngW'(hlat_q) <<< 4;
      default: th = AngW'(plat_q) <<< 4;
    endcase
    // inputs stay within +-2 turns; bring into (-180, 180]
    t0 = th;
    if (t0 > DegHalf) t0 = t0 - DegFull;
    if (t0 > DegHalf) t0 = t0 - DegFull;
    if (t0 <= -DegHalf) t0 = t0 + DegFull;
    if (t0 <= -DegHalf) t0 = t0 + DegFull;
    flip = 1'b0;
    t1 = t0;
    if (t0 > DegQuarter) begin t1 = DegHalf - t0; flip = 1'b1; end
    else if (t0 < -DegQuarter) begin t1 = -DegHalf - t0; flip = 1'b1; end
  end
  logic flip_q;

  function automatic logic signed [DatW-1:0] clampq(input logic signed [DatW-1:0] v);
    if (v > Q30) clampq = Q30;
    else if (v < -Q30) clampq = -Q30;
    else clampq = v;
  endfunction

  // one shared multiplier, result registered; cc*s2sq waits for cc_q
  logic signed [DatW-1:0] ma, mb;
  logic signed [2*DatW-1:0] mp_q;
  logic signed [DatW-1:0] s1sq_q, s2sq_q, cc_q;
  always_comb begin
    unique case (pr_q)
      3'd0: begin ma = s1_q; mb = s1_q; end
      3'd1: begin ma = s2_q; mb = s2_q; end
      3'd2: begin ma = c1_q; mb = c2_q; end
      default: begin ma = cc_q; mb = s2sq_q; end
    endcase
  end

  logic signed [DatW+1:0] asum;
  assign asum = (DatW+2)'(s1sq_q) + (DatW+2)'(mp_q >>> 30);

  logic [63:0] dprod;
  assign dprod = 64'(z_q[27:0]) * 64'(DistMul) + 64'h8000_0000;

  logic skip;
  assign skip = (s_axis_tdata[IdBits-1:0] == hid_q[IdBits-1:0]);

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:    if (s_axis_tvalid && s_axis_tready)
                    st_d = skip ? ST_UPDATE : ST_SC_LOAD;
      ST_SC_LOAD: st_d = ST_SC_RUN;
      ST_SC_RUN:  if (cdone) st_d = (sc_q == 2'd3) ? ST_PROD : ST_SC_LOAD;
      ST_PROD:    if (pr_q == 3'd5) st_d = ST_SQ_LOAD;
      ST_SQ_LOAD: st_d = ST_SQ_RUN;
      ST_SQ_RUN:  if (sdone) st_d = sq_q ? ST_AT_RUN : ST_SQ_LOAD;
      ST_AT_RUN:  if (cdone || ry_q == '0) st_d = ST_DIST;
      ST_DIST:    st_d = ST_UPDATE;
      ST_UPDATE:  st_d = last_q ? ST_OUT : ST_IDLE;
      ST_OUT:     st_d = ST_IDLE;
      default:    st_d = ST_IDLE;
    endcase
  end

  // unit commands
  logic at_start_q;
  always_comb begin
    cmd = '0;
    sstart = 1'b0;
    sval = sq_q ? (62'(Q30 - a_q) << 30) : (62'(a_q) << 30);
    if (st_q == ST_SC_LOAD) begin
      cmd.start = 1'b1; cmd.angle = t1; cmd.x0 = CordicStart; cmd.y0 = '0;
    end
    if (at_start_q) begin
      cmd.start = 1'b1; cmd.vec_mode = 1'b1; cmd.angle = '0;
      cmd.x0 = rx_q; cmd.y0 = ry_q;
    end
    if (st_q == ST_SQ_LOAD) sstart = 1'b1;
  end

  always_comb begin
    sc_d = sc_q; pr_d = pr_q; sq_d = sq_q;
    if (st_q == ST_SC_RUN && cdone) sc_d = sc_q + 1'b1;
    if (st_q == ST_PROD) pr_d = pr_q + 1'b1;
    if (st_q == ST_SQ_RUN && sdone) sq_d = ~sq_q;
    if (st_q == ST_IDLE) begin sc_d = '0; pr_d = '0; sq_d = 1'b0; end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; sc_q <= '0; pr_q <= '0; sq_q <= 1'b0;
      hlat_q <= '0; hlon_q <= '0; hid_q <= '0;
      bnd_q <= NearReset; bni_q <= '0; nv_q <= 1'b0;
      bfd_q <= '0; bfi_q <= '0; fv_q <= 1'b0;
      ov_q <= 1'b0; at_start_q <= 1'b0;
    end else begin
      st_q <= st_d; sc_q <= sc_d; pr_q <= pr_d; sq_q <= sq_d;
      at_start_q <= (st_q == ST_SQ_RUN) && sdone && sq_q && (ry_q != '0);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgHomeLat: hlat_q <= cfg_wdata_i[LatW-1:0];
          CfgHomeLon: hlon_q <= cfg_wdata_i;
          CfgHomeId:  hid_q  <= cfg_wdata_i[IdW-1:0];
          default: ;
        endcase
      end
      if (st_q == ST_UPDATE && !skip_q) begin
        if (dist_q < bnd_q) begin bnd_q <= dist_q; bni_q <= pid_q; nv_q <= 1'b1; end
        if (dist_q > bfd_q) begin bfd_q <= dist_q; bfi_q <= pid_q; fv_q <= 1'b1; end
      end
      if (st_q == ST_OUT) begin
        ov_q <= 1'b1;
        bnd_q <= NearReset; bni_q <= '0; nv_q <= 1'b0;
        bfd_q <= '0; bfi_q <= '0; fv_q <= 1'b0;
      end else if (ov_q && m_axis_tready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && s_axis_tvalid && s_axis_tready) begin
      pid_q  <= s_axis_tdata[15:0];
      plat_q <= s_axis_tdata[39:16];
      plon_q <= s_axis_tdata[64:40];
      last_q <= s_axis_tlast;
      skip_q <= skip;
    end
    if (st_q == ST_SC_LOAD) flip_q <= flip;
    if (st_q == ST_SC_RUN && cdone) begin
      unique case (sc_q)
        2'd0: s1_q <= clampq(cy);
        2'd1: s2_q <= clampq(cy);
        2'd2: c1_q <= clampq(flip_q ? -cx : cx);
        default: c2_q <= clampq(flip_q ? -cx : cx);
      endcase
    end
    if (st_q == ST_PROD) begin
      mp_q <= ma * mb;
      case (pr_q)
        3'd1: s1sq_q <= DatW'(mp_q >>> 30);
        3'd2: s2sq_q <= DatW'(mp_q >>> 30);
        3'd3: cc_q   <= DatW'(mp_q >>> 30);
        3'd5: begin
          if (asum < 0) a_q <= '0;
          else if (asum > (DatW+2)'(Q30)) a_q <= Q30;
          else a_q <= DatW'(asum);
        end
        default: ;
      endcase
    end
    if (st_q == ST_SQ_RUN && sdone) begin
      if (sq_q) rx_q <= DatW'(sroot);
      else      ry_q <= DatW'(sroot);
    end
    if (st_q == ST_AT_RUN) begin
      if (ry_q == '0) z_q <= '0;
      else if (cz < 0) z_q <= '0;
      else if (cz > DegQuarter) z_q <= DegQuarter;
      else z_q <= cz;
    end
    if (st_q == ST_DIST)
      dist_q <= (dprod[63:32] > 32'(DistMax)) ? DistMax : dprod[32+DistW-1:32];
    if (st_q == ST_OUT)
      out_q <= {2'b00, fv_q, (fv_q ? bfd_q : DistW'(0)), (fv_q ? bfi_q : IdW'(0)),
                nv_q, (nv_q ? bnd_q : DistW'(0)), (nv_q ? bni_q : IdW'(0))};
  end

  assign s_axis_tready = (st_q == ST_IDLE) && !ov_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_q;
endmodule
`default_nettype wire

// ===== rtl/nfh_cordic.sv =====
`default_nettype none
// Shared CORDIC: rotation (sin/cos) or vectoring (atan), one iteration per cycle.
module nfh_cordic (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire nfh_pkg::cordic_cmd_t cmd_i,
  output logic                     done_o,
  output logic signed [nfh_pkg::DatW-1:0] x_o,
  output logic signed [nfh_pkg::DatW-1:0] y_o,
  output logic signed [nfh_pkg::AngW-1:0] z_o
);
  import nfh_pkg::*;

  logic signed [DatW-1:0] x_q, x_d, y_q, y_d;
  logic signed [AngW-1:0] z_q, z_d;
  logic [IterW-1:0] it_q, it_d;
  logic busy_q, busy_d, vec_q, vec_d;
  logic dir;

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; it_d = it_q; busy_d = busy_q; vec_d = vec_q;
    dir = vec_q ? (y_q > 0) : (z_q >= 0);
    if (cmd_i.start) begin
      x_d = cmd_i.x0; y_d = cmd_i.y0; z_d = cmd_i.angle;
      it_d = '0; busy_d = 1'b1; vec_d = cmd_i.vec_mode;
    end else if (busy_q) begin
      if (vec_q) begin
        if (dir) begin
          x_d = x_q + (y_q >>> it_q); y_d = y_q - (x_q >>> it_q);
          z_d = z_q + atan_lut(it_q);
        end else begin
          x_d = x_q - (y_q >>> it_q); y_d = y_q + (x_q >>> it_q);
          z_d = z_q - atan_lut(it_q);
        end
      end else begin
        if (dir) begin
          x_d = x_q - (y_q >>> it_q); y_d = y_q + (x_q >>> it_q);
          z_d = z_q - atan_lut(it_q);
        end else begin
          x_d = x_q + (y_q >>> it_q); y_d = y_q - (x_q >>> it_q);
          z_d = z_q + atan_lut(it_q);
        end
      end
      it_d = it_q + 1'b1;
      if (it_q == IterW'(Iters - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; it_q <= '0; vec_q <= 1'b0;
    end else begin
      busy_q <= busy_d; it_q <= it_d; vec_q <= vec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
  end

  logic busy_p_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) busy_p_q <= 1'b0;
    else         busy_p_q <= busy_q;
  end

  assign done_o = busy_p_q && !busy_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule
`default_nettype wire

// ===== rtl/nfh_sqrt.sv =====
`default_nettype none
// Bit-pair restoring square root of a 62-bit value, one result bit per cycle.
module nfh_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [61:0] val_i,
  output logic             done_o,
  output logic [30:0]      root_o
);
  logic [33:0] rem_q, rem_d;
  logic [30:0] root_q, root_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [35:0] trial;
  logic [35:0] cur;
  logic [61:0] src_q, src_d;

  always_comb begin
    rem_d = rem_q; root_d = root_q; cnt_d = cnt_q; busy_d = busy_q;
    src_d = src_q; done_d = 1'b0;
    cur   = {rem_q, src_q[61:60]};
    trial = {3'b000, root_q, 2'b01};
    if (start_i) begin
      rem_d = '0; root_d = '0; cnt_d = '0; busy_d = 1'b1; src_d = val_i;
    end else if (busy_q) begin
      src_d = {src_q[59:0], 2'b00};
      if (cur >= trial) begin
        rem_d  = 34'(cur - trial);
        root_d = {root_q[29:0], 1'b1};
      end else begin
        rem_d  = 34'(cur);
        root_d = {root_q[29:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == 5'd30) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; done_q <= 1'b0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; root_q <= root_d; src_q <= src_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule
`default_nettype wire
